// File: hw/rtl/pcnt_pkg.sv
// ----------------------------------------------------------------------------
// pcnt_pkg
// Shared types and constants of the per-channel note tracker.
// ----------------------------------------------------------------------------
package pcnt_pkg;

	localparam int CHANNEL_COUNT_DEF = 16;
	localparam int NOTE_COUNT        = 128;
	localparam int NOTE_W            = 7;
	localparam int COUNT_W           = 16;
	localparam int FRAC_W            = 16;
	localparam int ACTIVE_W          = 23;
	localparam int LAST_W            = 8;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
	localparam logic [LAST_W-1:0]  NO_NOTE   = 8'hFF;

	typedef enum logic [2:0] {
		MODE_NOTE_ON  = 3'd0,
		MODE_NOTE_OFF = 3'd1,
		MODE_POLY_AT  = 3'd2,
		MODE_ALL_OFF  = 3'd3,
		MODE_QUERY    = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ
	} state_t;

	// per-note press state
	typedef struct packed {
		logic               pressed;
		logic [COUNT_W-1:0] count;
	} press_t;

	// per-note stored values
	typedef struct packed {
		logic [FRAC_W-1:0] velocity;
		logic [FRAC_W-1:0] aftertouch;
	} tone_t;

	// per-channel info; last_vel mirrors the velocity stored at the last note
	typedef struct packed {
		logic [LAST_W-1:0] last;
		logic [FRAC_W-1:0] override;
		logic [FRAC_W-1:0] last_vel;
	} chan_t;

endpackage

// File: hw/rtl/pcnt_ram.sv
// ----------------------------------------------------------------------------
// pcnt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcnt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hw/rtl/per_channel_note_tracker_core.sv
// ----------------------------------------------------------------------------
// per_channel_note_tracker_core
// Note and channel state tracker: one read-modify-write per item.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | mode, channel, note, amount
//  out     | output    | out_valid / out_ready| accepted ... last_note
//
// Accepting an item issues the memory reads; once the output register is free,
// the item is modified, written back and loaded into it. After reset, and after
// every all-notes-off, a clearing pass sweeps the press and active memories, one
// entry a cycle, and after reset the tone and channel memories too; in_ready is
// low during it. Only one item is in flight; the result waits in the output
// register while out_ready is low and the block can take the next.
// ----------------------------------------------------------------------------
module per_channel_note_tracker_core
	import pcnt_pkg::*;
#(
	parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          mode,
	input  logic [7:0]          channel,
	input  logic [7:0]          note,
	input  logic [FRAC_W-1:0]   amount,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                accepted,
	output logic                note_pressed,
	output logic [COUNT_W-1:0]  press_count,
	output logic [FRAC_W-1:0]   note_velocity,
	output logic [FRAC_W-1:0]   note_aftertouch,
	output logic [ACTIVE_W-1:0] active_notes,
	output logic [FRAC_W-1:0]   velocity_override,
	output logic [LAST_W-1:0]   last_note
);

	localparam int SLOTS  = CHANNEL_COUNT * NOTE_COUNT;
	localparam int CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam logic [SLOT_W-1:0] SWEEP_LAST = SLOT_W'(SLOTS - 1);
	localparam logic [SLOT_W-1:0] SWEEP_CH   = SLOT_W'(CHANNEL_COUNT);

	state_t state_q, state_d;
	logic              full_q;
	logic [SLOT_W-1:0] sweep_q;

	logic [2:0]        mode_q;
	logic [SLOT_W-1:0] idx_q;
	logic [CH_W-1:0]   ch_q;
	logic [NOTE_W-1:0] note_q;
	logic [FRAC_W-1:0] amount_q;
	logic              ok_q;

	logic in_acc, out_free, ok_in, do_wb, sweeping;
	logic [SLOT_W-1:0] idx_in;

	// memory ports
	press_t p_rd, p_new, p_wr;
	tone_t  t_rd, t_new, t_wr;
	chan_t  c_rd, c_new, c_wr;
	logic [ACTIVE_W-1:0] a_rd, a_new, a_wr;
	logic p_we, t_we, c_we, a_we;
	logic [SLOT_W-1:0] slot_wa;
	logic [CH_W-1:0]   ch_wa;

	logic                out_valid_q;
	logic                accepted_q, note_pressed_q;
	logic [COUNT_W-1:0]  press_count_q;
	logic [FRAC_W-1:0]   note_velocity_q, note_aftertouch_q, velocity_override_q;
	logic [ACTIVE_W-1:0] active_notes_q;
	logic [LAST_W-1:0]   last_note_q;

	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign ok_in    = ({1'b0, channel} < 9'(CHANNEL_COUNT)) && !note[7];
	assign idx_in   = SLOT_W'({channel[CH_W-1:0], note[NOTE_W-1:0]});
	assign do_wb    = (state_q == ST_READ) && out_free;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (sweep_q == SWEEP_LAST) state_d = ST_IDLE;
			ST_IDLE:  if (in_valid) state_d = ST_READ;
			ST_READ: begin
				if (out_free) begin
					state_d = (mode_q == MODE_ALL_OFF) ? ST_CLEAR : ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		sweeping = (state_q == ST_CLEAR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			full_q  <= 1'b1;
			sweep_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				sweep_q <= sweep_q + 1'b1;
				if (sweep_q == SWEEP_LAST) full_q <= 1'b0;
			end else begin
				sweep_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q   <= mode;
			idx_q    <= idx_in;
			ch_q     <= channel[CH_W-1:0];
			note_q   <= note[NOTE_W-1:0];
			amount_q <= amount;
			ok_q     <= ok_in;
		end
	end

	// modify
	always_comb begin
		p_new = p_rd;
		t_new = t_rd;
		c_new = c_rd;
		a_new = a_rd;
		case (mode_q)
			MODE_NOTE_ON: begin
				if (!c_rd.last[7]) c_new.override = c_rd.last_vel;
				t_new.velocity = amount_q;
				c_new.last     = {1'b0, note_q};
				c_new.last_vel = amount_q;
				if (p_rd.count != COUNT_MAX) begin
					p_new.count = p_rd.count + 1'b1;
					a_new       = a_rd + 1'b1;
				end
				p_new.pressed = 1'b1;
			end
			MODE_NOTE_OFF: begin
				if (p_rd.count != '0) begin
					p_new.count = p_rd.count - 1'b1;
					if (p_rd.count == COUNT_W'(1)) p_new.pressed = 1'b0;
					if (a_rd != '0) a_new = a_rd - 1'b1;
				end
			end
			MODE_POLY_AT: t_new.aftertouch = amount_q;
			MODE_ALL_OFF: begin
				p_new = '0;
				a_new = '0;
			end
			default: ;
		endcase
	end

	// write port select: clearing pass or write-back
	always_comb begin
		if (sweeping) begin
			slot_wa = sweep_q;
			ch_wa   = sweep_q[CH_W-1:0];
			p_we    = 1'b1;
			p_wr    = '0;
			t_we    = full_q;
			t_wr    = '0;
			a_we    = (sweep_q < SWEEP_CH);
			a_wr    = '0;
			c_we    = full_q && (sweep_q < SWEEP_CH);
			c_wr    = '{last: NO_NOTE, override: '0, last_vel: '0};
		end else begin
			slot_wa = idx_q;
			ch_wa   = ch_q;
			p_we    = do_wb && ok_q;
			p_wr    = p_new;
			t_we    = do_wb && ok_q;
			t_wr    = t_new;
			a_we    = do_wb && ok_q;
			a_wr    = a_new;
			c_we    = do_wb && ok_q;
			c_wr    = c_new;
		end
	end

	pcnt_ram #(.WIDTH($bits(press_t)), .DEPTH(SLOTS)) u_press_ram (
		.clk     (clk),
		.wr_en   (p_we),
		.wr_addr (slot_wa),
		.wr_data (p_wr),
		.rd_en   (in_acc),
		.rd_addr (idx_in),
		.rd_data (p_rd)
	);

	pcnt_ram #(.WIDTH($bits(tone_t)), .DEPTH(SLOTS)) u_tone_ram (
		.clk     (clk),
		.wr_en   (t_we),
		.wr_addr (slot_wa),
		.wr_data (t_wr),
		.rd_en   (in_acc),
		.rd_addr (idx_in),
		.rd_data (t_rd)
	);

	pcnt_ram #(.WIDTH(ACTIVE_W), .DEPTH(CHANNEL_COUNT)) u_active_ram (
		.clk     (clk),
		.wr_en   (a_we),
		.wr_addr (ch_wa),
		.wr_data (a_wr),
		.rd_en   (in_acc),
		.rd_addr (channel[CH_W-1:0]),
		.rd_data (a_rd)
	);

	pcnt_ram #(.WIDTH($bits(chan_t)), .DEPTH(CHANNEL_COUNT)) u_chan_ram (
		.clk     (clk),
		.wr_en   (c_we),
		.wr_addr (ch_wa),
		.wr_data (c_wr),
		.rd_en   (in_acc),
		.rd_addr (channel[CH_W-1:0]),
		.rd_data (c_rd)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_wb) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wb) begin
			accepted_q          <= ok_q;
			note_pressed_q      <= ok_q ? p_new.pressed : 1'b0;
			press_count_q       <= ok_q ? p_new.count : '0;
			note_velocity_q     <= ok_q ? t_new.velocity : '0;
			note_aftertouch_q   <= ok_q ? t_new.aftertouch : '0;
			active_notes_q      <= ok_q ? a_new : '0;
			velocity_override_q <= ok_q ? c_new.override : '0;
			last_note_q         <= ok_q ? c_new.last : NO_NOTE;
		end
	end

	assign out_valid         = out_valid_q;
	assign accepted          = accepted_q;
	assign note_pressed      = note_pressed_q;
	assign press_count       = press_count_q;
	assign note_velocity     = note_velocity_q;
	assign note_aftertouch   = note_aftertouch_q;
	assign active_notes      = active_notes_q;
	assign velocity_override = velocity_override_q;
	assign last_note         = last_note_q;

`ifndef SYNTHESIS
	a_accept_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_READ)
		else $error("accepted item not followed by read cycle");

	a_reject_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> last_note == NO_NOTE && press_count == '0
			&& active_notes == '0)
		else $error("out-of-range result not cleared");

	a_pressed_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> note_pressed == (press_count != '0))
		else $error("pressed bit disagrees with press count");

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == MODE_ALL_OFF |=> ##1 !in_ready)
		else $error("item accepted during clearing pass");
`endif

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for per_channel_note_tracker_core. Directed items hit the
// field extremes, every mode, out-of-range addresses and repeated presses of
// one note. Random traffic then runs note on/off sequences over a small note
// pool with noise, under random sender gaps and receiver stalls. Each result is
// checked against an in-bench tracker model.
// ----------------------------------------------------------------------------
module testbench
	import pcnt_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHANNELS       = CHANNEL_COUNT_DEF;
	localparam int SLOTS          = CHANNELS * NOTE_COUNT;
	localparam int RANDOM_ITEMS   = 1000;
	localparam int REPEAT_PRESSES = 24;
	localparam int CYCLE_LIMIT    = 10_000_000;
	localparam int MAX_PRINTS     = 40;
	localparam int DRAIN_CYCLES   = 16;

	// modes the block treats as a query
	localparam logic [2:0] MODE_SPARE_LO = 3'd5;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	typedef struct packed {
		logic                accepted;
		logic                pressed;
		logic [COUNT_W-1:0]  count;
		logic [FRAC_W-1:0]   velocity;
		logic [FRAC_W-1:0]   aftertouch;
		logic [ACTIVE_W-1:0] active;
		logic [FRAC_W-1:0]   override;
		logic [LAST_W-1:0]   last;
	} note_status_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [2:0] mode;
	logic [7:0] channel;
	logic [7:0] note;
	logic [FRAC_W-1:0] amount;
	logic out_valid;
	logic out_ready;
	logic accepted;
	logic note_pressed;
	logic [COUNT_W-1:0] press_count;
	logic [FRAC_W-1:0] note_velocity;
	logic [FRAC_W-1:0] note_aftertouch;
	logic [ACTIVE_W-1:0] active_notes;
	logic [FRAC_W-1:0] velocity_override;
	logic [LAST_W-1:0] last_note;

	// tracker model state
	logic [COUNT_W-1:0]  cnt_mem [SLOTS];
	logic                prs_mem [SLOTS];
	logic [FRAC_W-1:0]   vel_mem [SLOTS];
	logic [FRAC_W-1:0]   aft_mem [SLOTS];
	logic [ACTIVE_W-1:0] chan_active [CHANNELS];
	logic [LAST_W-1:0]   chan_last [CHANNELS];
	logic [FRAC_W-1:0]   chan_ovr [CHANNELS];

	note_status_t pending_status[$];
	note_status_t want_status;
	note_status_t got_status;

	int errors = 0;
	int cycles = 0;
	int burst_left = 0;
	bit steady = 1'b0;
	int ready_pct = 100;
	int stall_phase = 0;
	logic [7:0] note_pool [6];

	per_channel_note_tracker_core #(
		.CHANNEL_COUNT(CHANNELS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.channel(channel),
		.note(note),
		.amount(amount),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accepted(accepted),
		.note_pressed(note_pressed),
		.press_count(press_count),
		.note_velocity(note_velocity),
		.note_aftertouch(note_aftertouch),
		.active_notes(active_notes),
		.velocity_override(velocity_override),
		.last_note(last_note)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
	endtask

	function automatic void clear_tracker();
		foreach (cnt_mem[i]) begin
			cnt_mem[i] = '0;
			prs_mem[i] = 1'b0;
			vel_mem[i] = '0;
			aft_mem[i] = '0;
		end
		foreach (chan_active[i]) begin
			chan_active[i] = '0;
			chan_last[i] = NO_NOTE;
			chan_ovr[i] = '0;
		end
	endfunction

	function automatic note_status_t track_note_event(input logic [2:0] op,
			input logic [7:0] ch, input logic [7:0] nt, input logic [FRAC_W-1:0] amt);
		note_status_t st;
		int slot;
		int c;
		st = '0;
		st.last = NO_NOTE;
		c = int'(ch);
		if (op == MODE_ALL_OFF) begin
			foreach (cnt_mem[i]) begin
				cnt_mem[i] = '0;
				prs_mem[i] = 1'b0;
			end
			foreach (chan_active[i])
				chan_active[i] = '0;
		end
		if (c >= CHANNELS || int'(nt) >= NOTE_COUNT)
			return st;
		slot = c * NOTE_COUNT + int'(nt);
		case (op)
			MODE_NOTE_ON: begin
				// override takes the previous last note's velocity before the write
				if (int'(chan_last[c]) < NOTE_COUNT)
					chan_ovr[c] = vel_mem[c * NOTE_COUNT + int'(chan_last[c])];
				vel_mem[slot] = amt;
				chan_last[c] = nt;
				if (cnt_mem[slot] != COUNT_MAX) begin
					cnt_mem[slot] = cnt_mem[slot] + 1'b1;
					chan_active[c] = chan_active[c] + 1'b1;
				end
				prs_mem[slot] = 1'b1;
			end
			MODE_NOTE_OFF: begin
				if (cnt_mem[slot] != '0) begin
					cnt_mem[slot] = cnt_mem[slot] - 1'b1;
					if (cnt_mem[slot] == '0)
						prs_mem[slot] = 1'b0;
					if (chan_active[c] != '0)
						chan_active[c] = chan_active[c] - 1'b1;
				end
			end
			MODE_POLY_AT: begin
				aft_mem[slot] = amt;
			end
			default: ;
		endcase
		st.accepted = 1'b1;
		st.pressed = prs_mem[slot];
		st.count = cnt_mem[slot];
		st.velocity = vel_mem[slot];
		st.aftertouch = aft_mem[slot];
		st.active = chan_active[c];
		st.override = chan_ovr[c];
		st.last = chan_last[c];
		return st;
	endfunction

	// Called right after a rising edge; returns right after the accepting edge.
	task automatic send_item(input logic [2:0] op, input logic [7:0] ch,
			input logic [7:0] nt, input logic [FRAC_W-1:0] amt);
		int gap;
		if (!steady && burst_left == 0) begin
			gap = $urandom_range(0, 6);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		mode <= op;
		channel <= ch;
		note <= nt;
		amount <= amt;
		do @(posedge clk); while (!in_ready);
		pending_status.push_back(track_note_event(op, ch, nt, amt));
		if (burst_left > 0)
			burst_left--;
	endtask

	// receiver: phases of random length, each with its own ready rate
	always @(posedge clk) begin
		if (steady) begin
			out_ready <= 1'b1;
		end else begin
			if (stall_phase == 0) begin
				case ($urandom_range(0, 3))
					0: ready_pct = 100;
					1: ready_pct = 75;
					2: ready_pct = 50;
					default: ready_pct = 25;
				endcase
				stall_phase = $urandom_range(5, 80);
			end
			stall_phase--;
			out_ready <= ($urandom_range(0, 99) < ready_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_status = '{accepted, note_pressed, press_count, note_velocity,
				note_aftertouch, active_notes, velocity_override, last_note};
			if (pending_status.size() == 0) begin
				flag_mismatch("unexpected result", 32'(got_status.last), 32'(NO_NOTE));
			end else begin
				want_status = pending_status.pop_front();
				if (got_status.accepted !== want_status.accepted)
					flag_mismatch("accepted", 32'(got_status.accepted),
						32'(want_status.accepted));
				if (got_status.pressed !== want_status.pressed)
					flag_mismatch("note_pressed", 32'(got_status.pressed),
						32'(want_status.pressed));
				if (got_status.count !== want_status.count)
					flag_mismatch("press_count", 32'(got_status.count),
						32'(want_status.count));
				if (got_status.velocity !== want_status.velocity)
					flag_mismatch("note_velocity", 32'(got_status.velocity),
						32'(want_status.velocity));
				if (got_status.aftertouch !== want_status.aftertouch)
					flag_mismatch("note_aftertouch", 32'(got_status.aftertouch),
						32'(want_status.aftertouch));
				if (got_status.active !== want_status.active)
					flag_mismatch("active_notes", 32'(got_status.active),
						32'(want_status.active));
				if (got_status.override !== want_status.override)
					flag_mismatch("velocity_override", 32'(got_status.override),
						32'(want_status.override));
				if (got_status.last !== want_status.last)
					flag_mismatch("last_note", 32'(got_status.last),
						32'(want_status.last));
			end
		end
	end

	task automatic test_idle_state();
		send_item(MODE_QUERY, 8'd0, 8'd0, 16'h0000);
		send_item(MODE_QUERY, 8'(CHANNELS - 1), 8'(NOTE_COUNT - 1), 16'hFFFF);
	endtask

	task automatic test_press_release();
		send_item(MODE_NOTE_ON, 8'd3, 8'd60, 16'hFFFF);
		send_item(MODE_NOTE_ON, 8'd3, 8'd64, 16'h0000);
		send_item(MODE_NOTE_ON, 8'd3, 8'd64, 16'h8000);
		send_item(MODE_NOTE_OFF, 8'd3, 8'd60, 16'h1234);
		// release of a note that is already up
		send_item(MODE_NOTE_OFF, 8'd3, 8'd60, 16'h0000);
		send_item(MODE_NOTE_OFF, 8'd3, 8'd64, 16'hFFFF);
	endtask

	task automatic test_aftertouch();
		send_item(MODE_POLY_AT, 8'd3, 8'd64, 16'hA5A5);
		send_item(MODE_POLY_AT, 8'(CHANNELS - 1), 8'(NOTE_COUNT - 1), 16'hFFFF);
	endtask

	task automatic test_out_of_range();
		send_item(MODE_NOTE_ON, 8'(CHANNELS), 8'd0, 16'hFFFF);
		send_item(MODE_POLY_AT, 8'hFF, 8'd5, 16'h1234);
		send_item(MODE_NOTE_ON, 8'd0, 8'(NOTE_COUNT), 16'hFFFF);
		send_item(MODE_QUERY, 8'd3, 8'hFF, 16'h0000);
		send_item(MODE_NOTE_OFF, 8'd200, 8'd64, 16'h0000);
	endtask

	task automatic test_spare_modes();
		for (int m = int'(MODE_SPARE_LO); m <= int'(MODE_SPARE_HI); m++)
			send_item(3'(m), 8'd3, 8'd64, 16'h5A5A);
	endtask

	task automatic test_all_off();
		// clears even when the address is out of range
		send_item(MODE_ALL_OFF, 8'hFF, 8'hFF, 16'hFFFF);
		send_item(MODE_QUERY, 8'd3, 8'd64, 16'h0000);
		send_item(MODE_NOTE_ON, 8'd3, 8'd64, 16'h0001);
		send_item(MODE_ALL_OFF, 8'd3, 8'd64, 16'h0000);
	endtask

	// back-to-back presses stack on one note, then one release too many
	task automatic test_repeat_press();
		steady = 1'b1;
		for (int i = 0; i < REPEAT_PRESSES; i++)
			send_item(MODE_NOTE_ON, 8'd9, 8'(NOTE_COUNT - 1), 16'(i));
		for (int i = 0; i <= REPEAT_PRESSES; i++)
			send_item(MODE_NOTE_OFF, 8'd9, 8'(NOTE_COUNT - 1), 16'h0000);
		steady = 1'b0;
		burst_left = 0;
	endtask

	task automatic test_random_traffic();
		int pick;
		logic [2:0] op;
		logic [7:0] ch;
		logic [7:0] nt;
		logic [FRAC_W-1:0] amt;
		foreach (note_pool[i])
			note_pool[i] = 8'($urandom_range(0, NOTE_COUNT - 1));
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			ch = 8'($urandom_range(0, CHANNELS - 1));
			nt = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, NOTE_COUNT - 1))
				: note_pool[$urandom_range(0, 5)];
			case ($urandom_range(0, 9))
				0: amt = 16'h0000;
				1: amt = 16'hFFFF;
				default: amt = 16'($urandom());
			endcase
			pick = $urandom_range(0, 199);
			if (pick < 70) begin
				op = MODE_NOTE_ON;
			end else if (pick < 130) begin
				op = MODE_NOTE_OFF;
			end else if (pick < 150) begin
				op = MODE_POLY_AT;
			end else if (pick < 168) begin
				op = MODE_QUERY;
			end else if (pick < 174) begin
				op = 3'($urandom_range(int'(MODE_SPARE_LO), int'(MODE_SPARE_HI)));
			end else if (pick < 177) begin
				op = MODE_ALL_OFF;
				note_pool[$urandom_range(0, 5)] = 8'($urandom_range(0, NOTE_COUNT - 1));
			end else begin
				// noise: any mode at a bad address
				op = 3'($urandom_range(0, 7));
				if ($urandom_range(0, 1) == 0) begin
					ch = 8'($urandom_range(CHANNELS, 255));
					nt = 8'($urandom_range(0, 255));
				end else begin
					nt = 8'($urandom_range(NOTE_COUNT, 255));
				end
			end
			send_item(op, ch, nt, amt);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid <= 1'b0;
		out_ready <= 1'b0;
		mode <= MODE_QUERY;
		channel <= '0;
		note <= '0;
		amount <= '0;
		clear_tracker();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_idle_state();
		test_press_release();
		test_aftertouch();
		test_out_of_range();
		test_spare_modes();
		test_all_off();
		test_repeat_press();
		test_random_traffic();

		in_valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: per_channel_note_tracker_core.f
hw/rtl/pcnt_pkg.sv
hw/rtl/pcnt_ram.sv
hw/rtl/per_channel_note_tracker_core.sv
dv/testbench.sv
